>>> src/btbq_pkg.sv
// ----------------------------------------------------------------------------
// btbq_pkg
// Shared types and constants for the bass/treble biquad cascade.
// ----------------------------------------------------------------------------
package btbq_pkg;

	localparam int COEF_BITS          = 16;
	localparam int FF_W               = 3 * COEF_BITS;
	localparam int FB_W               = 2 * COEF_BITS;
	localparam int CFG_DATA_W         = FF_W;
	localparam int CFG_IDX_W          = 2;
	localparam int NUM_TERMS          = 5;
	localparam int DEF_SAMPLE_WIDTH   = 16;
	localparam int DEF_COEF_FRAC_BITS = 14;

	localparam logic [FF_W-1:0] FF_RESET = FF_W'(16384);
	localparam logic [FB_W-1:0] FB_RESET = '0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASS_FF,
		REG_BASS_FB,
		REG_TREBLE_FF,
		REG_TREBLE_FB
	} btbq_reg_t;

	typedef enum logic [2:0] {
		TERM_X0,
		TERM_X1,
		TERM_X2,
		TERM_Y1,
		TERM_Y2
	} btbq_term_t;

	typedef struct packed {
		logic       load;
		logic       mul_en;
		logic       stage;
		btbq_term_t term;
		logic       acc_clr;
		logic       acc_en;
		logic       round_en;
		logic       sat_en;
		logic       commit;
	} btbq_cmd_t;

	typedef struct packed {
		logic [FF_W-1:0] bass_ff;
		logic [FB_W-1:0] bass_fb;
		logic [FF_W-1:0] treble_ff;
		logic [FB_W-1:0] treble_fb;
	} btbq_coef_t;

endpackage

>>> src/btbq_cfg_regs.sv
// ----------------------------------------------------------------------------
// btbq_cfg_regs
// Coefficient register file, written over the configuration channel.
// ----------------------------------------------------------------------------
module btbq_cfg_regs import btbq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output btbq_coef_t            coefs
);

	btbq_coef_t coefs_q;

	assign cfg_ready = 1'b1;
	assign coefs     = coefs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs_q.bass_ff   <= FF_RESET;
			coefs_q.bass_fb   <= FB_RESET;
			coefs_q.treble_ff <= FF_RESET;
			coefs_q.treble_fb <= FB_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (btbq_reg_t'(cfg_index))
				REG_BASS_FF:   coefs_q.bass_ff   <= cfg_data[FF_W-1:0];
				REG_BASS_FB:   coefs_q.bass_fb   <= cfg_data[FB_W-1:0];
				REG_TREBLE_FF: coefs_q.treble_ff <= cfg_data[FF_W-1:0];
				REG_TREBLE_FB: coefs_q.treble_fb <= cfg_data[FB_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

>>> src/btbq_ctrl.sv
// ----------------------------------------------------------------------------
// btbq_ctrl
// Sequencer: steps the shared multiply-accumulate through both stages and
// owns the input and output handshakes.
// ----------------------------------------------------------------------------
module btbq_ctrl import btbq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	output btbq_cmd_t cmd
);

	localparam int CNT_W = $clog2(NUM_TERMS + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MAC,
		S_ROUND,
		S_SAT,
		S_WRITE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             stage_q;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			stage_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_MAC;
						cnt_q   <= '0;
						stage_q <= 1'b0;
					end
				end
				S_MAC: begin
					if (cnt_q == CNT_W'(NUM_TERMS)) begin
						state_q <= S_ROUND;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_ROUND: state_q <= S_SAT;
				S_SAT: begin
					if (!stage_q) begin
						stage_q <= 1'b1;
						cnt_q   <= '0;
						state_q <= S_MAC;
					end else begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.stage    = stage_q;
		cmd.term     = btbq_term_t'(cnt_q[2:0]);
		cmd.load     = (state_q == S_IDLE) && in_valid;
		cmd.mul_en   = (state_q == S_MAC) && (cnt_q < CNT_W'(NUM_TERMS));
		cmd.acc_clr  = (state_q == S_MAC) && (cnt_q == '0);
		cmd.acc_en   = (state_q == S_MAC) && (cnt_q != '0);
		cmd.round_en = (state_q == S_ROUND);
		cmd.sat_en   = (state_q == S_SAT);
		cmd.commit   = (state_q == S_WRITE) && out_free;
	end

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(out_valid_q && out_stall))
		else $error("result overwritten while output stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("not busy after accepting a beat");

	a_one_phase: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.mul_en, cmd.round_en, cmd.sat_en, cmd.commit}))
		else $error("overlapping datapath commands");

endmodule

>>> src/btbq_datapath.sv
// ----------------------------------------------------------------------------
// btbq_datapath
// History registers, one shared multiplier and accumulator, rounding toward
// zero and saturation, and the output register.
// ----------------------------------------------------------------------------
module btbq_datapath import btbq_pkg::*; #(
	parameter int SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
	parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  btbq_cmd_t                      cmd,
	input  btbq_coef_t                     coefs,
	input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
	input  logic                           block_start,
	output logic signed [SAMPLE_WIDTH-1:0] out_sample,
	output logic                           clipped
);

	localparam int PROD_W  = COEF_BITS + SAMPLE_WIDTH;
	localparam int ACC_MIN = PROD_W + 3;
	localparam int ACC_W   = (ACC_MIN > COEF_FRAC_BITS + 1) ? ACC_MIN : COEF_FRAC_BITS + 1;

	localparam logic signed [ACC_W-1:0] BIAS =
		{{(ACC_W - COEF_FRAC_BITS){1'b0}}, {COEF_FRAC_BITS{1'b1}}};
	localparam logic signed [ACC_W-1:0] ZERO = '0;
	localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	logic signed [SAMPLE_WIDTH-1:0] x_q, mid_q, res_q;
	logic signed [SAMPLE_WIDTH-1:0] in_d1_q, in_d2_q, mid_d1_q, mid_d2_q, out_d1_q, out_d2_q;
	logic signed [SAMPLE_WIDTH-1:0] out_sample_q;
	logic                           clipped_q, clip_acc_q;
	logic signed [PROD_W-1:0]       prod_s1;
	logic signed [ACC_W-1:0]        acc_q, q_q, biased;
	logic signed [SAMPLE_WIDTH-1:0] opnd, sat_val;
	logic signed [COEF_BITS-1:0]    coef;
	logic [FF_W-1:0]                ff;
	logic [FB_W-1:0]                fb;
	logic [ACC_W-SAMPLE_WIDTH:0]    upper;
	logic                           in_range;

	assign ff = cmd.stage ? coefs.treble_ff : coefs.bass_ff;
	assign fb = cmd.stage ? coefs.treble_fb : coefs.bass_fb;

	always_comb begin
		case (cmd.term)
			TERM_X0: begin
				opnd = cmd.stage ? mid_q : x_q;
				coef = ff[COEF_BITS-1:0];
			end
			TERM_X1: begin
				opnd = cmd.stage ? mid_d1_q : in_d1_q;
				coef = ff[2*COEF_BITS-1:COEF_BITS];
			end
			TERM_X2: begin
				opnd = cmd.stage ? mid_d2_q : in_d2_q;
				coef = ff[3*COEF_BITS-1:2*COEF_BITS];
			end
			TERM_Y1: begin
				opnd = cmd.stage ? out_d1_q : mid_d1_q;
				coef = fb[COEF_BITS-1:0];
			end
			TERM_Y2: begin
				opnd = cmd.stage ? out_d2_q : mid_d2_q;
				coef = fb[2*COEF_BITS-1:COEF_BITS];
			end
			default: begin
				opnd = '0;
				coef = '0;
			end
		endcase
	end

	// truncation toward zero: bias negative sums before the arithmetic shift
	assign biased = acc_q + (acc_q[ACC_W-1] ? BIAS : ZERO);

	assign upper    = q_q[ACC_W-1:SAMPLE_WIDTH-1];
	assign in_range = (&upper) || !(|upper);
	assign sat_val  = in_range ? q_q[SAMPLE_WIDTH-1:0] : (q_q[ACC_W-1] ? SMIN : SMAX);

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_s1 <= coef * opnd;
		end
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (cmd.acc_en) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
		if (cmd.round_en) begin
			q_q <= biased >>> COEF_FRAC_BITS;
		end
		if (cmd.load) begin
			x_q        <= in_sample;
			clip_acc_q <= 1'b0;
		end else if (cmd.sat_en) begin
			clip_acc_q <= clip_acc_q | !in_range;
		end
		if (cmd.sat_en && !cmd.stage) begin
			mid_q <= sat_val;
		end
		if (cmd.sat_en && cmd.stage) begin
			res_q <= sat_val;
		end
		if (cmd.commit) begin
			out_sample_q <= res_q;
			clipped_q    <= clip_acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_d1_q  <= '0;
			in_d2_q  <= '0;
			mid_d1_q <= '0;
			mid_d2_q <= '0;
			out_d1_q <= '0;
			out_d2_q <= '0;
		end else if (cmd.load && block_start) begin
			in_d1_q  <= '0;
			in_d2_q  <= '0;
			mid_d1_q <= '0;
			mid_d2_q <= '0;
			out_d1_q <= '0;
			out_d2_q <= '0;
		end else if (cmd.commit) begin
			in_d2_q  <= in_d1_q;
			in_d1_q  <= x_q;
			mid_d2_q <= mid_d1_q;
			mid_d1_q <= mid_q;
			out_d2_q <= out_d1_q;
			out_d1_q <= res_q;
		end
	end

	assign out_sample = out_sample_q;
	assign clipped    = clipped_q;

endmodule

>>> src/bass_treble_biquad_cascade.sv
// ----------------------------------------------------------------------------
// bass_treble_biquad_cascade
// Two direct form 1 biquads in series (bass, then treble) on one shared
// multiply-accumulate unit, with a saturating output per stage.
//
// Input channel: in_valid / in_stall carry in_sample and block_start. A beat
// with block_start set clears all six history registers before it is used.
// Output channel: out_valid / out_stall carry out_sample and clipped; the
// result sits in an output register and holds while out_stall is high.
// Configuration: cfg_valid / cfg_ready write cfg_data into the coefficient
// register picked by cfg_index; cfg_ready is always high. Write only while idle.
// Sequence: each stage runs 5 products through the one shared multiplier,
// then one drain, round and saturate; bass first, then treble. A new sample
// is taken only once the last result has moved to the output register.
// The next sample may be accepted while a result still waits; its own
// result is held back until the waiting one is taken.
// Reset: coefficients return to pass-through (b0 = 1.0), history clears to
// zero, both channels go idle.
// ----------------------------------------------------------------------------
module bass_treble_biquad_cascade import btbq_pkg::*; #(
	parameter int SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
	parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
	input  logic                           block_start,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] out_sample,
	output logic                           clipped,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [CFG_IDX_W-1:0]           cfg_index,
	input  logic [CFG_DATA_W-1:0]          cfg_data
);

	btbq_cmd_t  cmd;
	btbq_coef_t coefs;

	btbq_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coefs     (coefs)
	);

	btbq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	btbq_datapath #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.coefs       (coefs),
		.in_sample   (in_sample),
		.block_start (block_start),
		.out_sample  (out_sample),
		.clipped     (clipped)
	);

endmodule
